[src/c2s_pkg.sv]
`default_nettype none

package c2s_pkg;

    localparam int unsigned AccW     = 42;
    localparam int unsigned VecW     = 64;
    localparam int unsigned NormBits = 122;
    localparam int unsigned RhoBits  = 61;
    localparam int unsigned RadiusW  = 32;
    localparam int unsigned AzW      = 25;
    localparam int unsigned ElW      = 24;
    localparam int unsigned QW       = AccW - 16;

    typedef logic signed [AccW-1:0] t_acc;
    typedef logic signed [VecW-1:0] t_vec;
    typedef logic signed [QW-1:0]   t_q16;

    localparam longint DegPerRadQ56 = 64'sd4128596020240314225;
    localparam t_acc   Deg90        = t_acc'(longint'(90) <<< 32);
    localparam t_q16   AzLimit      = t_q16'(11796480);
    localparam t_q16   ElLimit      = t_q16'(5898240);

    // floor quotient of nonnegative operands by shift and subtract
    function automatic longint div_floor(input longint num, input longint den);
        longint quo;
        longint rem;
        int     b;
        quo = 0;
        rem = 0;
        for (b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (longint'(1) <<< b);
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in degrees, LSB 2^-32 degree
    function automatic longint micro_angle(input int unsigned idx);
        longint      sum;
        longint      term;
        int unsigned k;
        int unsigned sh;
        sum = 0;
        if (idx == 0) begin
            return longint'(45) <<< 32;
        end
        for (k = 0; idx * (2 * k + 1) < 63; k++) begin
            sh   = idx * (2 * k + 1);
            term = div_floor(DegPerRadQ56 >>> sh, longint'(2 * k + 1));
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum + (longint'(1) <<< 23)) >>> 24;
    endfunction

endpackage

`default_nettype wire

[src/c2s_delay.sv]
`default_nettype none

module c2s_delay #(
    parameter type         T     = logic,
    parameter int unsigned DEPTH = 1
) (
    input  wire logic i_clk,
    input  wire T     i_d,
    output T          o_q
);

    T r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

`default_nettype wire

[src/c2s_lead_cell.sv]
`default_nettype none

module c2s_lead_cell #(
    parameter int unsigned OPW = 64,
    parameter int unsigned IDX = 0
) (
    input  wire logic                       i_clk,
    input  wire logic [OPW-1:0]             i_op,
    input  wire logic [$clog2(OPW+1)-1:0]   i_nb,
    output logic      [OPW-1:0]             o_op,
    output logic      [$clog2(OPW+1)-1:0]   o_nb
);

    localparam int unsigned NbW = $clog2(OPW + 1);

    logic [OPW-1:0] r_op;
    logic [NbW-1:0] r_nb;
    logic [NbW-1:0] n_nb;
    logic [1:0]     pair;

    assign pair = i_op[OPW-1 -: 2];

    always_comb begin
        n_nb = i_nb;
        if (i_nb == '0 && pair != 2'b00) begin
            n_nb = pair[1] ? NbW'(OPW - 2 * IDX) : NbW'(OPW - 2 * IDX - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= {i_op[OPW-3:0], 2'b00};
        r_nb <= n_nb;
    end

    assign o_op = r_op;
    assign o_nb = r_nb;

endmodule

`default_nettype wire

[src/c2s_sqrt_cell.sv]
`default_nettype none

module c2s_sqrt_cell #(
    parameter int unsigned RW = 32
) (
    input  wire logic              i_clk,
    input  wire logic [2*RW-1:0]   i_op,
    input  wire logic [RW-1:0]     i_root,
    input  wire logic [RW+1:0]     i_rem,
    output logic      [2*RW-1:0]   o_op,
    output logic      [RW-1:0]     o_root,
    output logic      [RW+1:0]     o_rem
);

    logic [2*RW-1:0] r_op;
    logic [RW-1:0]   r_root;
    logic [RW+1:0]   r_rem;
    logic [RW+3:0]   full;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    assign full  = {i_rem, i_op[2*RW-1 -: 2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign diff  = full - trial;
    assign ge    = (full >= trial);

    always_ff @(posedge i_clk) begin
        r_op   <= {i_op[2*RW-3:0], 2'b00};
        r_root <= {i_root[RW-2:0], ge};
        r_rem  <= ge ? diff[RW+1:0] : full[RW+1:0];
    end

    assign o_op   = r_op;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[src/c2s_cordic_cell.sv]
`default_nettype none

module c2s_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  wire logic          i_clk,
    input  wire c2s_pkg::t_vec i_x,
    input  wire c2s_pkg::t_vec i_y,
    input  wire c2s_pkg::t_acc i_acc,
    output c2s_pkg::t_vec      o_x,
    output c2s_pkg::t_vec      o_y,
    output c2s_pkg::t_acc      o_acc
);

    import c2s_pkg::*;

    localparam t_acc Angle = t_acc'(micro_angle(STAGE));

    t_vec r_x;
    t_vec r_y;
    t_acc r_acc;
    t_vec dx;
    t_vec dy;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (i_y > 0) begin
            r_x   <= i_x + dx;
            r_y   <= i_y - dy;
            r_acc <= i_acc + Angle;
        end else begin
            r_x   <= i_x - dx;
            r_y   <= i_y + dy;
            r_acc <= i_acc - Angle;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;

endmodule

`default_nettype wire

[src/cartesian_to_spherical.sv]
`default_nettype none

// Throughput: one point per cycle; busy stays low, start may be held every cycle.
// The radius square root takes one cell per result bit, the horizontal-length root
// 61 cells, and each CORDIC one cell per stage.
// Reset clears the valid pipeline only. Each result beat shows for one cycle;
// the receiver cannot stall.
module cartesian_to_spherical #(
    parameter int unsigned COORD_WIDTH   = 32,
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]      i_pos_z,
    output logic                                    o_valid,
    output logic [c2s_pkg::RadiusW-1:0]             o_radius,
    output logic signed [c2s_pkg::AzW-1:0]          o_azimuth,
    output logic signed [c2s_pkg::ElW-1:0]          o_elevation,
    output logic                                    o_at_origin
);

    import c2s_pkg::*;

    localparam int unsigned W    = COORD_WIDTH;
    localparam int unsigned H    = (W + 1) / 2;
    localparam int unsigned HW   = W - H;
    localparam int unsigned NbW  = $clog2(2 * W + 1);
    localparam int unsigned Lat  = RhoBits + COORD_WIDTH + CORDIC_STAGES + 6;

    typedef struct packed {
        logic [W-1:0] mx;
        logic [W-1:0] my;
        logic [W-1:0] mz;
        logic         nx;
        logic         ny;
        logic         nz;
    } t_pt;

    typedef struct packed {
        logic [2*W-1:0] h2;
        t_pt            pt;
    } t_side;

    typedef struct packed {
        logic [RadiusW-1:0] rad;
        logic               origin;
        logic               polar;
        logic               nz;
    } t_flags;

    logic [Lat-1:0] r_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Lat-2:0], accept};
        end
    end

    // magnitude and sign
    t_pt r_s0;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0.nx <= i_pos_x[W-1];
            r_s0.ny <= i_pos_y[W-1];
            r_s0.nz <= i_pos_z[W-1];
            r_s0.mx <= i_pos_x[W-1] ? (~i_pos_x + W'(1)) : i_pos_x;
            r_s0.my <= i_pos_y[W-1] ? (~i_pos_y + W'(1)) : i_pos_y;
            r_s0.mz <= i_pos_z[W-1] ? (~i_pos_z + W'(1)) : i_pos_z;
        end
    end

    // partial products
    logic [2*H-1:0]  r_ll [3];
    logic [W-1:0]    r_lh [3];
    logic [2*HW-1:0] r_hh [3];
    t_pt             r_s1;
    logic [W-1:0]    mag  [3];

    assign mag[0] = r_s0.mx;
    assign mag[1] = r_s0.my;
    assign mag[2] = r_s0.mz;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_ll[c] <= (2*H)'(mag[c][H-1:0]) * (2*H)'(mag[c][H-1:0]);
            r_lh[c] <= W'(mag[c][H-1:0]) * W'(mag[c][W-1:H]);
            r_hh[c] <= (2*HW)'(mag[c][W-1:H]) * (2*HW)'(mag[c][W-1:H]);
        end
        r_s1 <= r_s0;
    end

    // squares
    logic [2*W-1:0] r_sq [3];
    t_pt            r_s2;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_sq[c] <= ((2*W)'(r_hh[c]) << (2 * H)) + ((2*W)'(r_lh[c]) << (H + 1))
                     + (2*W)'(r_ll[c]);
        end
        r_s2 <= r_s1;
    end

    // sums of squares
    logic [2*W-1:0] r_h2;
    logic [2*W-1:0] r_r2;
    t_pt            r_s3;

    always_ff @(posedge i_clk) begin
        r_h2 <= r_sq[0] + r_sq[1];
        r_r2 <= r_sq[0] + r_sq[1] + r_sq[2];
        r_s3 <= r_s2;
    end

    // radius root and leading-bit counts
    logic [2*W-1:0] rad_op   [W+1];
    logic [W-1:0]   rad_root [W+1];
    logic [W+1:0]   rad_rem  [W+1];
    logic [2*W-1:0] lr_op    [W+1];
    logic [NbW-1:0] lr_nb    [W+1];
    logic [2*W-1:0] lh_op    [W+1];
    logic [NbW-1:0] lh_nb    [W+1];

    assign rad_op[0]   = r_r2;
    assign rad_root[0] = '0;
    assign rad_rem[0]  = '0;
    assign lr_op[0]    = r_r2;
    assign lr_nb[0]    = '0;
    assign lh_op[0]    = r_h2;
    assign lh_nb[0]    = '0;

    for (genvar i = 0; i < W; i++) begin : g_rad
        c2s_sqrt_cell #(.RW(W)) u_sqrt (
            .i_clk  (i_clk),
            .i_op   (rad_op[i]),
            .i_root (rad_root[i]),
            .i_rem  (rad_rem[i]),
            .o_op   (rad_op[i+1]),
            .o_root (rad_root[i+1]),
            .o_rem  (rad_rem[i+1])
        );
        c2s_lead_cell #(.OPW(2 * W), .IDX(i)) u_lead_r (
            .i_clk (i_clk),
            .i_op  (lr_op[i]),
            .i_nb  (lr_nb[i]),
            .o_op  (lr_op[i+1]),
            .o_nb  (lr_nb[i+1])
        );
        c2s_lead_cell #(.OPW(2 * W), .IDX(i)) u_lead_h (
            .i_clk (i_clk),
            .i_op  (lh_op[i]),
            .i_nb  (lh_nb[i]),
            .o_op  (lh_op[i+1]),
            .o_nb  (lh_nb[i+1])
        );
    end

    t_side side_in;
    t_side side_q;

    assign side_in.h2 = r_h2;
    assign side_in.pt = r_s3;

    c2s_delay #(.T(t_side), .DEPTH(W)) u_side_dly (
        .i_clk (i_clk),
        .i_d   (side_in),
        .o_q   (side_q)
    );

    // normalize and set up the angle stages
    logic                 round_up;
    logic [W:0]           rad_full;
    logic [63:0]          rad64;
    logic [6:0]           el_span;
    logic [6:0]           az_span;
    logic [5:0]           s_el;
    logic [5:0]           s_az;
    t_vec                 el_mag;
    t_vec                 sx;
    t_vec                 sy;

    assign round_up = rad_rem[W] > {2'b00, rad_root[W]};
    assign rad_full = (W+1)'(rad_root[W]) + (W+1)'(round_up);
    assign rad64    = 64'(rad_full);
    assign el_span  = 7'(NormBits) - 7'(lr_nb[W]);
    assign az_span  = 7'(NormBits) - 7'(lh_nb[W]);
    assign s_el     = el_span[6:1];
    assign s_az     = az_span[6:1];
    assign el_mag   = t_vec'(side_q.pt.mz) << s_el;
    assign sx       = t_vec'(side_q.pt.mx) << s_az;
    assign sy       = t_vec'(side_q.pt.my) << s_az;

    t_flags              r_flags;
    logic [NormBits-1:0] r_rho_op;
    t_vec                r_el_y;
    t_vec                r_az_x;
    t_vec                r_az_y;
    t_acc                r_az_acc;

    always_ff @(posedge i_clk) begin
        r_flags.rad    <= (rad64 > 64'hFFFF_FFFF) ? '1 : rad64[RadiusW-1:0];
        r_flags.origin <= (lr_nb[W] == '0);
        r_flags.polar  <= (lh_nb[W] == '0);
        r_flags.nz     <= side_q.pt.nz;
        r_rho_op       <= NormBits'(side_q.h2) << {s_el, 1'b0};
        r_el_y         <= side_q.pt.nz ? -el_mag : el_mag;
        if (side_q.pt.nx) begin
            if (!side_q.pt.ny) begin
                r_az_x   <= sy;
                r_az_y   <= sx;
                r_az_acc <= Deg90;
            end else begin
                r_az_x   <= sy;
                r_az_y   <= -sx;
                r_az_acc <= -Deg90;
            end
        end else begin
            r_az_x   <= sx;
            r_az_y   <= side_q.pt.ny ? -sy : sy;
            r_az_acc <= '0;
        end
    end

    // horizontal length root
    logic [NormBits-1:0] rho_op   [RhoBits+1];
    logic [RhoBits-1:0]  rho_root [RhoBits+1];
    logic [RhoBits+1:0]  rho_rem  [RhoBits+1];

    assign rho_op[0]   = r_rho_op;
    assign rho_root[0] = '0;
    assign rho_rem[0]  = '0;

    for (genvar i = 0; i < RhoBits; i++) begin : g_rho
        c2s_sqrt_cell #(.RW(RhoBits)) u_sqrt (
            .i_clk  (i_clk),
            .i_op   (rho_op[i]),
            .i_root (rho_root[i]),
            .i_rem  (rho_rem[i]),
            .o_op   (rho_op[i+1]),
            .o_root (rho_root[i+1]),
            .o_rem  (rho_rem[i+1])
        );
    end

    t_vec el_y_q;

    c2s_delay #(.T(t_vec), .DEPTH(RhoBits)) u_ely_dly (
        .i_clk (i_clk),
        .i_d   (r_el_y),
        .o_q   (el_y_q)
    );

    // azimuth rotator
    t_vec az_x   [CORDIC_STAGES+1];
    t_vec az_y   [CORDIC_STAGES+1];
    t_acc az_acc [CORDIC_STAGES+1];

    assign az_x[0]   = r_az_x;
    assign az_y[0]   = r_az_y;
    assign az_acc[0] = r_az_acc;

    // elevation rotator
    t_vec el_x   [CORDIC_STAGES+1];
    t_vec el_y   [CORDIC_STAGES+1];
    t_acc el_acc [CORDIC_STAGES+1];

    assign el_x[0]   = t_vec'(rho_root[RhoBits]);
    assign el_y[0]   = el_y_q;
    assign el_acc[0] = '0;

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
        c2s_cordic_cell #(.STAGE(j)) u_az (
            .i_clk (i_clk),
            .i_x   (az_x[j]),
            .i_y   (az_y[j]),
            .i_acc (az_acc[j]),
            .o_x   (az_x[j+1]),
            .o_y   (az_y[j+1]),
            .o_acc (az_acc[j+1])
        );
        c2s_cordic_cell #(.STAGE(j)) u_el (
            .i_clk (i_clk),
            .i_x   (el_x[j]),
            .i_y   (el_y[j]),
            .i_acc (el_acc[j]),
            .o_x   (el_x[j+1]),
            .o_y   (el_y[j+1]),
            .o_acc (el_acc[j+1])
        );
    end

    t_acc   az_acc_q;
    t_flags flags_q;

    c2s_delay #(.T(t_acc), .DEPTH(RhoBits)) u_az_dly (
        .i_clk (i_clk),
        .i_d   (az_acc[CORDIC_STAGES]),
        .o_q   (az_acc_q)
    );

    c2s_delay #(.T(t_flags), .DEPTH(RhoBits + CORDIC_STAGES)) u_flag_dly (
        .i_clk (i_clk),
        .i_d   (r_flags),
        .o_q   (flags_q)
    );

    // round to 1/65536 degree and clamp
    function automatic t_q16 to_q16(input t_acc acc, input t_q16 lim);
        t_acc sum;
        t_q16 v;
        sum = acc + t_acc'(1 <<< 15);
        v   = sum[AccW-1:16];
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

    t_q16 az_q;
    t_q16 el_q;

    assign az_q = to_q16(az_acc_q, AzLimit);
    assign el_q = to_q16(el_acc[CORDIC_STAGES], ElLimit);

    logic [RadiusW-1:0]    r_radius;
    logic signed [AzW-1:0] r_azimuth;
    logic signed [ElW-1:0] r_elevation;
    logic                  r_at_origin;

    always_ff @(posedge i_clk) begin
        r_at_origin <= flags_q.origin;
        if (flags_q.origin) begin
            r_radius    <= '0;
            r_azimuth   <= '0;
            r_elevation <= '0;
        end else if (flags_q.polar) begin
            r_radius    <= flags_q.rad;
            r_azimuth   <= '0;
            r_elevation <= flags_q.nz ? -ElLimit[ElW-1:0] : ElLimit[ElW-1:0];
        end else begin
            r_radius    <= flags_q.rad;
            r_azimuth   <= az_q[AzW-1:0];
            r_elevation <= el_q[ElW-1:0];
        end
    end

    assign o_valid     = r_vld[Lat-1];
    assign o_radius    = r_radius;
    assign o_azimuth   = r_azimuth;
    assign o_elevation = r_elevation;
    assign o_at_origin = r_at_origin;

endmodule

`default_nettype wire

[tb/cartesian_to_spherical_test.sv]
`timescale 1ns / 100ps

module cartesian_to_spherical_test;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned N_STAGES = 24;
    localparam int unsigned LATENCY  = COORD_W + N_STAGES + 67;
    localparam int          N_RANDOM = 1750;
    localparam longint      DEG_PER_RAD_Q56 = 64'sd4128596020240314225;
    localparam longint      AZ_MAX = 64'sd11796480;
    localparam longint      EL_MAX = 64'sd5898240;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct {
        logic [c2s_pkg::RadiusW-1:0]    radius;
        logic signed [c2s_pkg::AzW-1:0] azimuth;
        logic signed [c2s_pkg::ElW-1:0] elevation;
        logic                           at_origin;
    } sphere_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_pos_x = '0;
    logic signed [COORD_W-1:0] i_pos_y = '0;
    logic signed [COORD_W-1:0] i_pos_z = '0;
    logic                      o_valid;
    logic [c2s_pkg::RadiusW-1:0]    o_radius;
    logic signed [c2s_pkg::AzW-1:0] o_azimuth;
    logic signed [c2s_pkg::ElW-1:0] o_elevation;
    logic                           o_at_origin;

    point_t  pending_points[$];
    sphere_t expected_spheres[$];
    longint  atan_steps[N_STAGES];
    int      mismatches = 0;
    int      gap_left = 0;
    int      burst_left = 0;

    cartesian_to_spherical #(
        .COORD_WIDTH  (COORD_W),
        .CORDIC_STAGES(N_STAGES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .o_valid    (o_valid),
        .o_radius   (o_radius),
        .o_azimuth  (o_azimuth),
        .o_elevation(o_elevation),
        .o_at_origin(o_at_origin)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint atan_step_deg(input int unsigned idx);
        longint      acc;
        longint      term;
        int unsigned k;
        acc = 0;
        if (idx == 0) begin
            return longint'(45) <<< 32;
        end
        for (k = 0; idx * (2 * k + 1) < 63; k++) begin
            term = (DEG_PER_RAD_Q56 >>> (idx * (2 * k + 1))) / longint'(2 * k + 1);
            acc = k[0] ? acc - term : acc + term;
        end
        return (acc + (longint'(1) <<< 23)) >>> 24;
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] a);
        logic [63:0]  root;
        logic [127:0] cand;
        root = '0;
        for (int b = 62; b >= 0; b--) begin
            cand = {64'd0, root | (64'd1 << b)};
            if (cand * cand <= a) begin
                root = cand[63:0];
            end
        end
        return root;
    endfunction

    function automatic int bit_length(input logic [127:0] a);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++) begin
            if (a[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic longint cordic_angle(input longint vx, input longint vy);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy;
                vy = -t;
                acc = longint'(90) <<< 32;
            end else begin
                vx = -vy;
                vy = t;
                acc = -(longint'(90) <<< 32);
            end
        end
        for (int i = 0; i < N_STAGES; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx;
                vy -= dy;
                acc += atan_steps[i];
            end else begin
                vx -= dx;
                vy += dy;
                acc -= atan_steps[i];
            end
        end
        return acc;
    endfunction

    function automatic longint round_deg(input longint acc, input longint lim);
        longint v;
        v = (acc + (longint'(1) <<< 15)) >>> 16;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [COORD_W-1:0] v);
        return v[COORD_W-1] ? (64'd1 << COORD_W) - {32'd0, v} : {32'd0, v};
    endfunction

    function automatic longint shifted(input logic [63:0] mag, input logic neg,
                                       input int s);
        longint v;
        v = longint'(mag << s);
        return neg ? -v : v;
    endfunction

    function automatic sphere_t convert_point(input point_t p);
        sphere_t      res;
        logic [63:0]  mx;
        logic [63:0]  my;
        logic [63:0]  mz;
        logic [127:0] h2;
        logic [127:0] r2;
        logic [127:0] rad;
        logic [63:0]  rho;
        longint       az;
        longint       el;
        int           s;
        mx = magnitude(p.x);
        my = magnitude(p.y);
        mz = magnitude(p.z);
        h2 = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
        r2 = h2 + {64'd0, mz} * {64'd0, mz};
        res = '{default: '0};
        if (r2 == 0) begin
            res.at_origin = 1'b1;
            return res;
        end
        rad = {64'd0, floor_root(r2)};
        if (r2 > rad * rad + rad) rad++;
        if (rad > 128'hFFFF_FFFF) rad = 128'hFFFF_FFFF;
        az = 0;
        if (h2 == 0) begin
            el = p.z[COORD_W-1] ? -EL_MAX : EL_MAX;
        end else begin
            s = (c2s_pkg::NormBits - bit_length(r2)) / 2;
            rho = floor_root(h2 << (2 * s));
            el = round_deg(cordic_angle(longint'(rho), shifted(mz, p.z[COORD_W-1], s)),
                           EL_MAX);
            s = (c2s_pkg::NormBits - bit_length(h2)) / 2;
            az = round_deg(cordic_angle(shifted(mx, p.x[COORD_W-1], s),
                                        shifted(my, p.y[COORD_W-1], s)), AZ_MAX);
        end
        res.radius    = rad[31:0];
        res.azimuth   = az[c2s_pkg::AzW-1:0];
        res.elevation = el[c2s_pkg::ElW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return '0;
            1, 2, 3: return $signed($urandom) >>> $urandom_range(1, 31);
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic int next_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_spheres.push_back(convert_point('{i_pos_x, i_pos_y, i_pos_z}));
            end
            if ((start && !busy) || !start) begin
                if (gap_left > 0 || pending_points.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    start <= 1'b0;
                end else begin
                    point_t p;
                    p = pending_points.pop_front();
                    i_pos_x <= p.x;
                    i_pos_y <= p.y;
                    i_pos_z <= p.z;
                    start   <= 1'b1;
                    gap_left = next_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_spheres.size() == 0) begin
                $display("%0t: result beat with nothing expected", $realtime);
                mismatches++;
            end else begin
                sphere_t want;
                want = expected_spheres.pop_front();
                if (o_radius !== want.radius)
                    report_mismatch("radius", longint'(o_radius), longint'(want.radius));
                if (o_azimuth !== want.azimuth)
                    report_mismatch("azimuth", longint'(o_azimuth), longint'(want.azimuth));
                if (o_elevation !== want.elevation)
                    report_mismatch("elevation", longint'(o_elevation),
                                    longint'(want.elevation));
                if (o_at_origin !== want.at_origin)
                    report_mismatch("at_origin", longint'(o_at_origin),
                                    longint'(want.at_origin));
            end
        end
    end

    initial begin
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        for (int i = 0; i < N_STAGES; i++) begin
            atan_steps[i] = atan_step_deg(i);
        end
        lo = 32'sh8000_0000;
        hi = 32'sh7FFF_FFFF;
        pending_points.push_back('{0, 0, 0});
        pending_points.push_back('{1, 0, 0});
        pending_points.push_back('{-1, 0, 0});
        pending_points.push_back('{lo, 0, 0});
        pending_points.push_back('{0, 1, 0});
        pending_points.push_back('{0, -1, 0});
        pending_points.push_back('{0, 0, 1});
        pending_points.push_back('{0, 0, -1});
        pending_points.push_back('{0, 0, lo});
        pending_points.push_back('{0, 0, hi});
        pending_points.push_back('{lo, lo, lo});
        pending_points.push_back('{hi, hi, hi});
        pending_points.push_back('{lo, hi, lo});
        pending_points.push_back('{hi, lo, hi});
        pending_points.push_back('{-1, -1, -1});
        pending_points.push_back('{1, 1, 1});
        pending_points.push_back('{-5, 0, 7});
        pending_points.push_back('{3, 4, 0});
        pending_points.push_back('{-3, -4, 12});
        pending_points.push_back('{1, -1, 0});
        pending_points.push_back('{lo, 1, -1});
        for (int n = 0; n < N_RANDOM; n++) begin
            pending_points.push_back('{random_coord(), random_coord(), random_coord()});
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending_points.size() != 0 || start || expected_spheres.size() != 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_spheres.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
src/c2s_pkg.sv
src/c2s_delay.sv
src/c2s_lead_cell.sv
src/c2s_sqrt_cell.sv
src/c2s_cordic_cell.sv
src/cartesian_to_spherical.sv
tb/cartesian_to_spherical_test.sv
